FILE: src/etbe_pkg.sv
package etbe_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned FreqW   = 25;
  localparam int unsigned StepW   = 20;
  localparam int unsigned ThreshW = 8;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 32;

  localparam logic [FreqW-1:0]  FreqMax     = {FreqW{1'b1}};
  localparam logic [FreqW-1:0]  FreqDefault = 25'd7000000;
  localparam logic [CountW-1:0] CountReset  = 32'hFFFF_FC19;

  localparam logic [StepW-1:0]   CoarseStepReset = 20'd1000;
  localparam logic [StepW-1:0]   FineStepReset   = 20'd100;
  localparam logic [ThreshW-1:0] ThresholdReset  = 8'd3;
  localparam logic [MsW-1:0]     HoldoffReset    = 16'd100;
  localparam logic [MsW-1:0]     DblClickReset   = 16'd500;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COARSE_STEP  = 3'd0,
    REG_FINE_STEP    = 3'd1,
    REG_MOVE_THRESH  = 3'd2,
    REG_TURN_HOLDOFF = 3'd3,
    REG_DBL_CLICK    = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [StepW-1:0]   coarse_step;
    logic [StepW-1:0]   fine_step;
    logic [ThreshW-1:0] move_threshold;
    logic [MsW-1:0]     turn_holdoff_ms;
    logic [MsW-1:0]     double_click_ms;
  } cfg_t;

endpackage

FILE: src/etbe_cfg.sv
module etbe_cfg
  import etbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_COARSE_STEP:  cfg_d.coarse_step     = cfg_data_i[StepW-1:0];
        REG_FINE_STEP:    cfg_d.fine_step       = cfg_data_i[StepW-1:0];
        REG_MOVE_THRESH:  cfg_d.move_threshold  = cfg_data_i[ThreshW-1:0];
        REG_TURN_HOLDOFF: cfg_d.turn_holdoff_ms = cfg_data_i[MsW-1:0];
        REG_DBL_CLICK:    cfg_d.double_click_ms = cfg_data_i[MsW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coarse_step     <= CoarseStepReset;
      cfg_q.fine_step       <= FineStepReset;
      cfg_q.move_threshold  <= ThresholdReset;
      cfg_q.turn_holdoff_ms <= HoldoffReset;
      cfg_q.double_click_ms <= DblClickReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/encoder_tuning_with_button_events.sv
// Rotary encoder frequency tuner with button press, release and double-click events.
// Input stream (s_axis): one request per poll carrying the encoder count, the
// button level (0 pressed) and a free-running millisecond timestamp.
// Output stream (m_axis): one result per request, in order: tuned frequency,
// step flag, press, release and double-click events, and the fine-mode flag
// that chose the step size of that poll.
// Config channel (cfg_*): register index and data; always ready, write only
// while the stream is idle. Unknown indexes are dropped.
// Accepted requests pass the input register, then the result register, to m_axis.
// Throughput: one request per cycle unless m_axis stalls; the tuner state loop
// (count compare, holdoff compare, one 25-bit add or subtract) is combinational.
// A request moves from the input register to the result register whenever
// the result register is empty or being taken, so s_axis stays ready while
// one result waits. When m_axis stalls with both registers full, s_axis_tready
// drops until the receiver takes the result.
// Reset clears both stage valids, loads the register defaults, frequency
// 7000000 and stored count -999.
module encoder_tuning_with_button_events
  import etbe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [31:0] encoder_count, [32] button_level, [64:33] time_ms, [71:65] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [24:0] frequency, [25] frequency_changed, [26] press_event,
  // [27] release_event, [28] double_click, [29] fine_mode, [31:30] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t cfg;

  etbe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic              in_vld_q;
  logic [CountW-1:0] in_count_q;
  logic              in_level_q;
  logic [TimeW-1:0]  in_time_q;

  logic              out_vld_q;
  logic [FreqW-1:0]  out_freq_q, out_freq_d;
  logic              out_chg_q, out_chg_d;
  logic              out_press_q, out_press_d;
  logic              out_rel_q, out_rel_d;
  logic              out_dbl_q, out_dbl_d;
  logic              out_fine_q;

  logic [CountW-1:0] stored_count_q, stored_count_d;
  logic [TimeW-1:0]  tune_time_q, tune_time_d;
  logic              prev_level_q;
  logic              held_q, held_d;
  logic [TimeW-1:0]  press_time_q, press_time_d;
  logic [FreqW-1:0]  freq_q;

  logic              out_adv;
  logic              in_adv;
  logic              proc;

  assign out_adv       = !out_vld_q || m_axis_tready;
  assign in_adv        = !in_vld_q || out_adv;
  assign s_axis_tready = in_adv;
  assign proc          = in_vld_q && out_adv;

  logic signed [CountW:0] diff;
  logic [CountW:0]        mag;
  logic                   moved;
  logic [TimeW-1:0]       tune_elapsed;
  logic                   tune_ok;
  logic [StepW-1:0]       step;
  logic [FreqW:0]         sum;
  logic [FreqW-1:0]       step_ext;
  logic [FreqW-1:0]       freq_up, freq_dn;
  logic [TimeW-1:0]       press_elapsed;
  logic                   press_edge, release_edge;

  always_comb begin
    step          = held_q ? cfg.fine_step : cfg.coarse_step;
    step_ext      = {{(FreqW-StepW){1'b0}}, step};
    diff          = $signed({in_count_q[CountW-1], in_count_q})
                  - $signed({stored_count_q[CountW-1], stored_count_q});
    mag           = diff[CountW] ? 33'(-diff) : 33'(diff);
    moved         = mag > {{(CountW+1-ThreshW){1'b0}}, cfg.move_threshold};
    tune_elapsed  = in_time_q - tune_time_q;
    tune_ok       = tune_elapsed > {{(TimeW-MsW){1'b0}}, cfg.turn_holdoff_ms};
    sum           = {1'b0, freq_q} + {1'b0, step_ext};
    freq_up       = sum[FreqW] ? FreqMax : sum[FreqW-1:0];
    freq_dn       = (freq_q > step_ext) ? (freq_q - step_ext) : '0;
    press_elapsed = in_time_q - press_time_q;
    press_edge    = prev_level_q && !in_level_q;
    release_edge  = !prev_level_q && in_level_q;

    stored_count_d = stored_count_q;
    tune_time_d    = tune_time_q;
    out_freq_d     = freq_q;
    out_chg_d      = 1'b0;
    if (moved) begin
      stored_count_d = in_count_q;
      if (tune_ok) begin
        out_freq_d  = diff[CountW] ? freq_dn : freq_up;
        out_chg_d   = 1'b1;
        tune_time_d = in_time_q;
      end
    end

    held_d       = held_q;
    press_time_d = press_time_q;
    out_press_d  = 1'b0;
    out_rel_d    = 1'b0;
    out_dbl_d    = 1'b0;
    if (press_edge) begin
      out_press_d  = 1'b1;
      held_d       = 1'b1;
      out_dbl_d    = press_elapsed < {{(TimeW-MsW){1'b0}}, cfg.double_click_ms};
      press_time_d = in_time_q;
    end else if (release_edge) begin
      out_rel_d = 1'b1;
      held_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q       <= 1'b0;
      out_vld_q      <= 1'b0;
      stored_count_q <= CountReset;
      tune_time_q    <= '0;
      prev_level_q   <= 1'b1;
      held_q         <= 1'b0;
      press_time_q   <= '0;
      freq_q         <= FreqDefault;
    end else begin
      if (in_adv) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_vld_q <= in_vld_q;
      end
      if (proc) begin
        stored_count_q <= stored_count_d;
        tune_time_q    <= tune_time_d;
        prev_level_q   <= in_level_q;
        held_q         <= held_d;
        press_time_q   <= press_time_d;
        freq_q         <= out_freq_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid) begin
      in_count_q <= s_axis_tdata[CountW-1:0];
      in_level_q <= s_axis_tdata[CountW];
      in_time_q  <= s_axis_tdata[CountW+TimeW:CountW+1];
    end
    if (proc) begin
      out_freq_q  <= out_freq_d;
      out_chg_q   <= out_chg_d;
      out_press_q <= out_press_d;
      out_rel_q   <= out_rel_d;
      out_dbl_q   <= out_dbl_d;
      out_fine_q  <= held_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_fine_q, out_dbl_q, out_rel_q, out_press_q,
                          out_chg_q, out_freq_q};

`ifndef NO_ASSERTIONS
  a_freq_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (freq_q == out_freq_q))
    else $error("tuner frequency differs from pending result");

  a_dbl_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_dbl_q |-> out_press_q && !out_rel_q)
    else $error("double click without press or with release");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q && !m_axis_tready)
    else $error("input stalled with free stage");

  a_held_follows_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> !prev_level_q)
    else $error("button held while last level released");
`endif

endmodule

FILE: tb/sv/tb.sv
module tb;
  import etbe_pkg::*;

  typedef struct packed {
    logic             fine_mode;
    logic             double_click;
    logic             release_ev;
    logic             press_ev;
    logic             freq_changed;
    logic [FreqW-1:0] freq;
  } tuner_reading_t;

  class tuner_tracker;
    cfg_t               cfg;
    logic [CountW-1:0]  stored_count;
    logic [TimeW-1:0]   last_tune_ms;
    logic [TimeW-1:0]   last_press_ms;
    logic               prev_level;
    logic               held;
    logic [FreqW-1:0]   freq;
    tuner_reading_t     tuner_readings[$];
    int                 fails;
    int                 taken;

    function new();
      cfg = '{CoarseStepReset, FineStepReset, ThresholdReset, HoldoffReset, DblClickReset};
      stored_count  = CountReset;
      last_tune_ms  = '0;
      last_press_ms = '0;
      prev_level    = 1'b1;
      held          = 1'b0;
      freq          = FreqDefault;
      fails         = 0;
      taken         = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_COARSE_STEP:  cfg.coarse_step     = data[StepW-1:0];
        REG_FINE_STEP:    cfg.fine_step       = data[StepW-1:0];
        REG_MOVE_THRESH:  cfg.move_threshold  = data[ThreshW-1:0];
        REG_TURN_HOLDOFF: cfg.turn_holdoff_ms = data[MsW-1:0];
        REG_DBL_CLICK:    cfg.double_click_ms = data[MsW-1:0];
        default: ;
      endcase
    endfunction

    function void apply_poll(logic [CountW-1:0] count, logic level, logic [TimeW-1:0] now);
      tuner_reading_t  r;
      logic [StepW-1:0] step;
      longint          diff;
      longint          thr;
      logic [FreqW:0]  sum;
      r = '0;
      r.fine_mode = held;
      step = held ? cfg.fine_step : cfg.coarse_step;
      diff = longint'($signed(count)) - longint'($signed(stored_count));
      thr = longint'(cfg.move_threshold);
      if (diff > thr || -diff > thr) begin
        if (TimeW'(now - last_tune_ms) > TimeW'(cfg.turn_holdoff_ms)) begin
          if (diff > 0) begin
            sum = {1'b0, freq} + (FreqW + 1)'(step);
            freq = (sum > {1'b0, FreqMax}) ? FreqMax : sum[FreqW-1:0];
          end else begin
            freq = (freq > FreqW'(step)) ? freq - FreqW'(step) : '0;
          end
          r.freq_changed = 1'b1;
          last_tune_ms = now;
        end
        stored_count = count;
      end
      if (prev_level && !level) begin
        r.press_ev = 1'b1;
        held = 1'b1;
        if (TimeW'(now - last_press_ms) < TimeW'(cfg.double_click_ms)) begin
          r.double_click = 1'b1;
        end
        last_press_ms = now;
      end else if (!prev_level && level) begin
        r.release_ev = 1'b1;
        held = 1'b0;
      end
      prev_level = level;
      r.freq = freq;
      tuner_readings.push_back(r);
    endfunction

    task report(string msg);
      $display("t=%0t reading %0d: %s", $time, taken, msg);
      fails++;
    endtask

    task take_reading(logic [OutDataW-1:0] data);
      tuner_reading_t got;
      tuner_reading_t want;
      got = data[$bits(tuner_reading_t)-1:0];
      taken++;
      if (tuner_readings.size() == 0) begin
        report($sformatf("unexpected reading %h", data));
        return;
      end
      want = tuner_readings.pop_front();
      if (got.freq !== want.freq)
        report($sformatf("frequency %0d, want %0d", got.freq, want.freq));
      if (got.freq_changed !== want.freq_changed)
        report($sformatf("frequency_changed %b, want %b", got.freq_changed, want.freq_changed));
      if (got.press_ev !== want.press_ev)
        report($sformatf("press_event %b, want %b", got.press_ev, want.press_ev));
      if (got.release_ev !== want.release_ev)
        report($sformatf("release_event %b, want %b", got.release_ev, want.release_ev));
      if (got.double_click !== want.double_click)
        report($sformatf("double_click %b, want %b", got.double_click, want.double_click));
      if (got.fine_mode !== want.fine_mode)
        report($sformatf("fine_mode %b, want %b", got.fine_mode, want.fine_mode));
    endtask

    function int pending();
      return tuner_readings.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tuner_tracker        sb = new();
  bit                  steady = 1'b0;
  int                  cur_count = 0;
  logic [TimeW-1:0]    cur_time = '0;
  logic                cur_level = 1'b1;

  encoder_tuning_with_button_events u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_poll(input logic [CountW-1:0] count, input logic level,
                           input logic [TimeW-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({now, level, count});
    do @(posedge clk_i); while (!s_axis_tready);
    sb.apply_poll(count, level, now);
  endtask

  // hold valid across back-to-back writes; caller drops it after the batch
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic set_tuning(input logic [StepW-1:0] coarse, input logic [StepW-1:0] fine,
                            input logic [ThreshW-1:0] thr, input logic [MsW-1:0] holdoff,
                            input logic [MsW-1:0] window);
    cfg_write(REG_COARSE_STEP, coarse);
    cfg_write(REG_FINE_STEP, fine);
    cfg_write(REG_MOVE_THRESH, {(CfgDataW - ThreshW)'($urandom), thr});
    cfg_write(REG_TURN_HOLDOFF, {(CfgDataW - MsW)'($urandom), holdoff});
    cfg_write(REG_DBL_CLICK, {(CfgDataW - MsW)'($urandom), window});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) sb.report($sformatf("%0d readings never came", sb.pending()));
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_polls(input int n, input int up_pct);
    int delta;
    int span;
    repeat (n) begin
      if ($urandom_range(0, 99) < 8) begin
        cur_count = $urandom;
        cur_time  = $urandom;
        cur_level = $urandom_range(0, 1);
      end else begin
        delta = $urandom_range(0, int'(sb.cfg.move_threshold) + 3);
        cur_count += ($urandom_range(0, 99) < up_pct) ? delta : -delta;
        span = $urandom_range(0, 1) ? int'(sb.cfg.turn_holdoff_ms)
                                    : int'(sb.cfg.double_click_ms);
        cur_time += TimeW'($urandom_range(0, span + span / 4 + 2));
        if ($urandom_range(0, 3) == 0) cur_level = ~cur_level;
      end
      send_poll(cur_count, cur_level, cur_time);
    end
    s_axis_tvalid <= 1'b0;
    drain();
  endtask

  initial begin : result_sink
    int gap;
    int seen;
    seen = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (seen == 100) gap = 80;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.take_reading(m_axis_tdata);
      seen++;
    end
  end

  initial begin : watchdog
    #3000000;
    $display("encoder_tuning_with_button_events regression: fail");
    $finish;
  end

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_poll(32'sd0, 1'b1, 32'd50);
    send_poll(32'sd3, 1'b1, 32'd60);
    send_poll(32'sd4, 1'b1, 32'd200);
    send_poll(32'sd8, 1'b1, 32'd300);
    send_poll(32'sd12, 1'b1, 32'd401);
    send_poll(32'sd12, 1'b0, 32'd450);
    send_poll(32'h8000_0000, 1'b0, 32'd1000);
    send_poll(32'h7FFF_FFFF, 1'b1, 32'd2000);
    send_poll(32'h7FFF_FFFF, 1'b0, 32'd2500);
    send_poll(32'h7FFF_FFFF, 1'b1, 32'd2600);
    send_poll(32'h7FFF_FFFF, 1'b0, 32'd2999);
    send_poll(32'h7FFF_FFFF, 1'b1, 32'd3100);
    send_poll(32'h7FFF_FFFF, 1'b0, 32'd3499);
    send_poll(32'h7FFF_FFFF, 1'b1, 32'd3500);
    send_poll(32'sd0, 1'b1, 32'hFFFF_FFF0);
    send_poll(-32'sd100, 1'b1, 32'h0000_0080);
    send_poll(-32'sd100, 1'b0, 32'hFFFF_FFFF);
    send_poll(32'sd0, 1'b1, 32'h0000_0010);
    cur_count = 0;
    cur_time  = 32'h0000_0010;
    run_polls(60, 50);

    set_tuning(20'd1000000, 20'd1, 8'd0, 16'd0, 16'hFFFF);
    run_polls(70, 90);
    steady = 1'b1;
    run_polls(50, 10);
    steady = 1'b0;

    set_tuning('0, '0, 8'hFF, 16'hFFFF, '0);
    cfg_write(CfgIdxW'($urandom_range(int'(REG_DBL_CLICK) + 1, (1 << CfgIdxW) - 1)),
              CfgDataW'($urandom));
    cfg_write(CfgIdxW'((1 << CfgIdxW) - 1), {CfgDataW{1'b1}});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    run_polls(50, 50);

    set_tuning({StepW{1'b1}}, {StepW{1'b1}}, ThreshW'($urandom_range(0, 8)),
               MsW'($urandom_range(0, 300)), MsW'($urandom_range(0, 600)));
    run_polls(60, 60);

    steady = 1'b1;
    set_tuning(StepW'($urandom_range(1, 50000)), StepW'($urandom_range(1, 5000)),
               ThreshW'($urandom_range(0, 10)), MsW'($urandom_range(0, 200)),
               MsW'($urandom_range(0, 800)));
    run_polls(50, 40);
    steady = 1'b0;

    set_tuning(StepW'($urandom), StepW'($urandom), ThreshW'($urandom),
               MsW'($urandom), MsW'($urandom));
    run_polls(40, 50);

    set_tuning(CoarseStepReset, FineStepReset, ThresholdReset, HoldoffReset, DblClickReset);
    run_polls(60, 50);

    if (sb.fails == 0) begin
      $display("encoder_tuning_with_button_events regression: pass");
    end else begin
      $display("encoder_tuning_with_button_events regression: fail");
    end
    $finish;
  end

endmodule
